// ===== src/hsbrgb_pkg.sv =====
// hsbrgb_pkg: shared types and constants for the HSB to RGB pixel converter.
// No dependencies.
package hsbrgb_pkg;

	localparam int CH_W = 8;
	localparam logic [CH_W-1:0] CH_MAX = 8'hff;

	localparam logic [7:0] SECT_0 = 8'd0;
	localparam logic [7:0] SECT_1 = 8'd1;
	localparam logic [7:0] SECT_2 = 8'd2;
	localparam logic [7:0] SECT_3 = 8'd3;
	localparam logic [7:0] SECT_4 = 8'd4;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} rgb_t;

	// color wheel corner for one hue
	function automatic rgb_t wheel(input logic [15:0] hue);
		logic [7:0] pos;
		rgb_t c;
		pos = hue[7:0];
		case (hue[15:8])
			SECT_0: begin
				c.red = CH_MAX; c.green = pos; c.blue = '0;
			end
			SECT_1: begin
				c.red = CH_MAX - pos; c.green = CH_MAX; c.blue = '0;
			end
			SECT_2: begin
				c.red = '0; c.green = CH_MAX; c.blue = pos;
			end
			SECT_3: begin
				c.red = '0; c.green = CH_MAX - pos; c.blue = CH_MAX;
			end
			SECT_4: begin
				c.red = pos; c.green = '0; c.blue = CH_MAX;
			end
			default: begin
				c.red = CH_MAX; c.green = '0; c.blue = CH_MAX - pos;
			end
		endcase
		return c;
	endfunction

endpackage

// ===== src/hsb_to_rgb_pixel_top.sv =====
// hsb_to_rgb_pixel_top: streaming HSB to RGB pixel converter, three-stage pipeline.
// Depends on hsbrgb_pkg.
//
// channel   dir  tdata (low bit up)                       tuser  tlast
// s_axis    in   hue[15:0] saturation[23:16] bright[31:24] -      -
// m_axis    out  red[7:0] green[15:8] blue[23:16]          -      -
//
// One item per cycle while the output is not held; each item passes through the
// stage 1, stage 2 and stage 3 registers before it is offered on m_axis.
// Stage 1 picks the wheel sector, stage 2 applies saturation (one 8x9 multiply
// per channel), stage 3 applies brightness and is the output register.
// Reset clears the stage valid bits only.
// When the output item is held, the whole pipeline holds and s_axis_tready drops.
module hsb_to_rgb_pixel_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // hue[15:0], saturation[23:16], brightness[31:24]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);
	import hsbrgb_pkg::*;

	logic        adv;
	logic        vld_s1, vld_s2, vld_s3;
	rgb_t        rgb_s1, rgb_s2, rgb_s3;
	logic [8:0]  sat_s1;
	logic [8:0]  bri_s1, bri_s2;
	logic [16:0] sat_prod_r, sat_prod_g, sat_prod_b;
	logic [16:0] bri_prod_r, bri_prod_g, bri_prod_b;

	assign adv = !vld_s3 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// saturation: c = 255 - ((255 - c) * (s + 1) >> 8)
	always_comb begin
		sat_prod_r = 17'(CH_MAX - rgb_s1.red) * 17'(sat_s1);
		sat_prod_g = 17'(CH_MAX - rgb_s1.green) * 17'(sat_s1);
		sat_prod_b = 17'(CH_MAX - rgb_s1.blue) * 17'(sat_s1);
	end

	// brightness: c = c * (b + 1) >> 8
	always_comb begin
		bri_prod_r = 17'(rgb_s2.red) * 17'(bri_s2);
		bri_prod_g = 17'(rgb_s2.green) * 17'(bri_s2);
		bri_prod_b = 17'(rgb_s2.blue) * 17'(bri_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s1 <= wheel(s_axis_tdata[15:0]);
			sat_s1 <= 9'(s_axis_tdata[23:16]) + 9'd1;
			bri_s1 <= 9'(s_axis_tdata[31:24]) + 9'd1;

			rgb_s2.red   <= CH_MAX - sat_prod_r[15:8];
			rgb_s2.green <= CH_MAX - sat_prod_g[15:8];
			rgb_s2.blue  <= CH_MAX - sat_prod_b[15:8];
			bri_s2       <= bri_s1;

			rgb_s3.red   <= bri_prod_r[15:8];
			rgb_s3.green <= bri_prod_g[15:8];
			rgb_s3.blue  <= bri_prod_b[15:8];
		end
	end

	assign m_axis_tvalid = vld_s3;
	assign m_axis_tdata  = rgb_s3;

endmodule

// ===== test/tb_hsb_to_rgb_pixel_top.sv =====
// tb_hsb_to_rgb_pixel_top: self-checking testbench for the HSB to RGB pixel converter.
// Drives hsb_to_rgb_pixel_top with directed and random pixels under varied idling and
// checks every RGB output against its own predictor. Depends on hsbrgb_pkg.
`timescale 1ns / 100ps

module tb_hsb_to_rgb_pixel_top;
	import hsbrgb_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;  // hue[15:0], saturation[23:16], brightness[31:24]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // red[7:0], green[15:8], blue[23:16]

	rgb_t        rgb_pending_q[$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	hsb_to_rgb_pixel_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// saturation pulls toward white, then brightness scales
	function automatic logic [7:0] shade(input logic [7:0] chan, input logic [7:0] sat,
			input logic [7:0] bri);
		int unsigned full;
		int unsigned c;
		full = CH_MAX;
		c = chan;
		c = full - (((full - c) * (int'(sat) + 1)) >> 8);
		c = (c * (int'(bri) + 1)) >> 8;
		return c[7:0];
	endfunction

	function automatic rgb_t hsb_to_rgb(input logic [15:0] hue, input logic [7:0] sat,
			input logic [7:0] bri);
		logic [7:0] pos;
		rgb_t px;
		pos = hue[7:0];
		case (hue[15:8])
			SECT_0: px = '{blue: 8'd0, green: pos, red: CH_MAX};
			SECT_1: px = '{blue: 8'd0, green: CH_MAX, red: CH_MAX - pos};
			SECT_2: px = '{blue: pos, green: CH_MAX, red: 8'd0};
			SECT_3: px = '{blue: CH_MAX, green: CH_MAX - pos, red: 8'd0};
			SECT_4: px = '{blue: CH_MAX, green: 8'd0, red: pos};
			default: px = '{blue: CH_MAX - pos, green: 8'd0, red: CH_MAX};
		endcase
		px.red = shade(px.red, sat, bri);
		px.green = shade(px.green, sat, bri);
		px.blue = shade(px.blue, sat, bri);
		return px;
	endfunction

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		rgb_t got;
		rgb_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (rgb_pending_q.size() == 0) begin
				$display("%0t: unexpected item, actual %h", $time, got);
				mismatch_count++;
			end else begin
				want = rgb_pending_q.pop_front();
				if (got.red !== want.red) begin
					$display("%0t: red expected %h actual %h", $time, want.red, got.red);
					mismatch_count++;
				end
				if (got.green !== want.green) begin
					$display("%0t: green expected %h actual %h", $time, want.green, got.green);
					mismatch_count++;
				end
				if (got.blue !== want.blue) begin
					$display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("hsb_to_rgb_pixel_top test failed");
			$finish;
		end
	end

	// called right after a falling edge, returns right after one
	task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
			input logic [7:0] bri);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {bri, sat, hue};
		do @(posedge clk); while (!s_axis_tready);
		rgb_pending_q.push_back(hsb_to_rgb(hue, sat, bri));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (rgb_pending_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_sector_corners();
		for (int sect = 0; sect < 6; sect++) begin
			send_pixel({sect[7:0], 8'h00}, 8'hff, 8'hff);
			send_pixel({sect[7:0], 8'hff}, 8'hff, 8'hff);
		end
		// sector bytes past five fold into the last sector
		send_pixel(16'h0680, 8'hff, 8'hff);
		send_pixel(16'hff80, 8'hc3, 8'h5a);
		send_pixel(16'hffff, 8'hff, 8'hff);
	endtask

	task automatic test_sat_bri_extremes();
		send_pixel(16'h0240, 8'h00, 8'hff);
		send_pixel(16'h0240, 8'hff, 8'h00);
		send_pixel(16'h0240, 8'h00, 8'h00);
		send_pixel(16'h03a5, 8'h80, 8'h7f);
		send_pixel(16'h0000, 8'h01, 8'hfe);
	endtask

	task automatic test_random_pixels(input int count, input int unsigned idle_pct,
			input int unsigned stall_pct);
		logic [15:0] hue;
		logic [7:0] sat;
		logic [7:0] bri;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			if ($urandom_range(99) < 80)
				hue = {8'($urandom_range(5)), 8'($urandom)};
			else
				hue = 16'($urandom);
			sat = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
			bri = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00) : 8'($urandom);
			send_pixel(hue, sat, bri);
		end
	endtask

	task automatic test_pause_until_drained();
		test_random_pixels(20, 0, 31);
		wait_drained();
		test_random_pixels(20, 0, 31);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_sector_corners();
		test_sat_bri_extremes();
		test_random_pixels(500, 0, 0);
		test_random_pixels(500, 75, 0);
		test_random_pixels(500, 0, 75);
		test_pause_until_drained();
		test_random_pixels(460, 31, 31);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("hsb_to_rgb_pixel_top test passed");
		else
			$display("hsb_to_rgb_pixel_top test failed");
		$finish;
	end

endmodule
